[rtl/sha1_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_pkg: shared types and constants of the SHA-1 digest engine
// Word and queue entry types, state encodings, round constants and the
// initial chaining value.
// ----------------------------------------------------------------------------
package sha1_pkg;

  localparam int WORD_W      = 32;
  localparam int BYTE_W      = 8;
  localparam int COUNT_W     = 61;
  localparam int ROUND_W     = 7;
  localparam int QUEUE_DEPTH = 4;

  // Round boundaries and last round
  localparam logic [ROUND_W-1:0] ROUND_STAGE1 = 7'd20;
  localparam logic [ROUND_W-1:0] ROUND_STAGE2 = 7'd40;
  localparam logic [ROUND_W-1:0] ROUND_STAGE3 = 7'd60;
  localparam logic [ROUND_W-1:0] ROUND_LAST   = 7'd79;

  // Word slots within a 16-word block
  localparam logic [3:0] LEN_HI_SLOT = 4'd14;
  localparam logic [3:0] LEN_LO_SLOT = 4'd15;

  // Index of the last digest word
  localparam logic [2:0] LAST_DIGEST_IDX = 3'd4;

  localparam logic [BYTE_W-1:0] PAD_MARK = 8'h80;

  localparam logic [WORD_W-1:0] K_STAGE0 = 32'h5A827999;
  localparam logic [WORD_W-1:0] K_STAGE1 = 32'h6ED9EBA1;
  localparam logic [WORD_W-1:0] K_STAGE2 = 32'h8F1BBCDC;
  localparam logic [WORD_W-1:0] K_STAGE3 = 32'hCA62C1D6;

  // Initial chaining value, h0 at index 0
  localparam logic [4:0][WORD_W-1:0] H_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  // One message word handed from the front end to the compression core
  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic              block_end;  // sixteenth word of a block
    logic              last_blk;   // closing block of a message
  } sha1_qword_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_PAD_FIRST,
    FE_PAD_BODY
  } front_state_t;

  typedef enum logic [1:0] {
    BE_LOAD,
    BE_ROUND,
    BE_UPDATE,
    BE_OUT
  } back_state_t;

  // Boolean function of a round
  function automatic logic [WORD_W-1:0] round_f(input logic [ROUND_W-1:0] idx,
                                                input logic [WORD_W-1:0] b,
                                                input logic [WORD_W-1:0] c,
                                                input logic [WORD_W-1:0] d);
    logic [WORD_W-1:0] f;
    if (idx < ROUND_STAGE1) begin
      f = (b & c) | (~b & d);
    end else if (idx < ROUND_STAGE2) begin
      f = b ^ c ^ d;
    end else if (idx < ROUND_STAGE3) begin
      f = (b & c) | (b & d) | (c & d);
    end else begin
      f = b ^ c ^ d;
    end
    return f;
  endfunction

  // Additive constant of a round
  function automatic logic [WORD_W-1:0] round_k(input logic [ROUND_W-1:0] idx);
    logic [WORD_W-1:0] k;
    if (idx < ROUND_STAGE1) begin
      k = K_STAGE0;
    end else if (idx < ROUND_STAGE2) begin
      k = K_STAGE1;
    end else if (idx < ROUND_STAGE3) begin
      k = K_STAGE2;
    end else begin
      k = K_STAGE3;
    end
    return k;
  endfunction

endpackage
`default_nettype wire

[rtl/sha1_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_if: channel interfaces of the SHA-1 digest engine
// Message byte channel and digest word channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sha1_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, msg_byte, has_byte, end_of_message, input ready);
  modport sink   (input valid, msg_byte, has_byte, end_of_message, output ready);
endinterface

interface sha1_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        word_last;

  modport source (output valid, digest_word, word_last, input ready);
  modport sink   (input valid, digest_word, word_last, output ready);
endinterface
`default_nettype wire

[rtl/sha1_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_front: message front end
// Packs bytes into big-endian words, counts the message length and, at the
// end of a message, generates the padding and length words.
// ----------------------------------------------------------------------------
module sha1_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  sha1_in_if.sink                    msg_in,
  output sha1_pkg::sha1_qword_t      q_data,
  output logic                       q_valid,
  input  wire logic                  q_ready
);

  sha1_pkg::front_state_t state, state_next;

  logic [sha1_pkg::COUNT_W-1:0] byte_count;
  logic [23:0]                  acc;
  logic [3:0]                   pad_idx;
  logic                         pad_extra;

  logic [1:0]  lane;
  logic [3:0]  widx;
  logic [63:0] bit_len;
  logic [31:0] mark_word;

  assign lane    = byte_count[1:0];
  assign widx    = byte_count[5:2];
  assign bit_len = {byte_count, 3'b000};

  // Word holding the bytes so far, the 0x80 marker and zero fill
  always_comb begin
    case (lane)
      2'd0:    mark_word = {sha1_pkg::PAD_MARK, 24'h0};
      2'd1:    mark_word = {acc[7:0], sha1_pkg::PAD_MARK, 16'h0};
      2'd2:    mark_word = {acc[15:0], sha1_pkg::PAD_MARK, 8'h0};
      default: mark_word = {acc[23:0], sha1_pkg::PAD_MARK};
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha1_pkg::FE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and queue push
  always_comb begin
    state_next   = state;
    msg_in.ready = 1'b0;
    q_valid      = 1'b0;
    q_data       = '0;
    case (state)
      sha1_pkg::FE_IDLE: begin
        msg_in.ready     = q_ready;
        q_valid          = msg_in.valid && msg_in.has_byte && (lane == 2'd3);
        q_data.word      = {acc, msg_in.msg_byte};
        q_data.block_end = (widx == 4'd15);
        if (msg_in.valid && q_ready && msg_in.end_of_message) begin
          state_next = sha1_pkg::FE_PAD_FIRST;
        end
      end
      sha1_pkg::FE_PAD_FIRST: begin
        q_valid          = 1'b1;
        q_data.word      = mark_word;
        q_data.block_end = (widx == 4'd15);
        if (q_ready) begin
          state_next = sha1_pkg::FE_PAD_BODY;
        end
      end
      sha1_pkg::FE_PAD_BODY: begin
        q_valid = 1'b1;
        if (pad_extra) begin
          q_data.block_end = (pad_idx == 4'd15);
        end else if (pad_idx == sha1_pkg::LEN_HI_SLOT) begin
          q_data.word = bit_len[63:32];
        end else if (pad_idx == sha1_pkg::LEN_LO_SLOT) begin
          q_data.word      = bit_len[31:0];
          q_data.block_end = 1'b1;
          q_data.last_blk  = 1'b1;
        end
        if (q_ready && !pad_extra && (pad_idx == sha1_pkg::LEN_LO_SLOT)) begin
          state_next = sha1_pkg::FE_IDLE;
        end
      end
      default: begin
        state_next = sha1_pkg::FE_IDLE;
      end
    endcase
  end

  // Byte count, word assembly and padding position
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      pad_idx    <= '0;
      pad_extra  <= 1'b0;
    end else begin
      case (state)
        sha1_pkg::FE_IDLE: begin
          if (msg_in.valid && q_ready && msg_in.has_byte) begin
            byte_count <= byte_count + 1'b1;
            acc        <= {acc[15:0], msg_in.msg_byte};
          end
        end
        sha1_pkg::FE_PAD_FIRST: begin
          if (q_ready) begin
            // Marker in slot 14 leaves no room for the length
            pad_extra <= (widx == sha1_pkg::LEN_HI_SLOT);
            pad_idx   <= widx + 1'b1;
          end
        end
        sha1_pkg::FE_PAD_BODY: begin
          if (q_ready) begin
            pad_idx <= pad_idx + 1'b1;
            if (pad_extra && (pad_idx == 4'd15)) begin
              pad_extra <= 1'b0;
            end
            if (!pad_extra && (pad_idx == sha1_pkg::LEN_LO_SLOT)) begin
              byte_count <= '0;
            end
          end
        end
        default: begin
          pad_extra <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/sha1_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_queue: word queue between front end and compression core
// Small first-in first-out buffer in flip-flops, valid/ready on both sides.
// ----------------------------------------------------------------------------
module sha1_queue #(
  parameter int DEPTH = sha1_pkg::QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sha1_pkg::sha1_qword_t in_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  output sha1_pkg::sha1_qword_t      out_data,
  output logic                       out_valid,
  input  wire logic                  out_ready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sha1_pkg::sha1_qword_t entries [DEPTH];

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/sha1_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_core: SHA-1 compression core
// Loads sixteen words into the schedule window, runs 80 rounds at one a
// cycle, folds the result into the chaining value and, after the last block of a message, emits the digest.
// ----------------------------------------------------------------------------
module sha1_core (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire sha1_pkg::sha1_qword_t q_data,
  input  wire logic                  q_valid,
  output logic                       q_ready,
  sha1_out_if.source                 digest_out
);

  localparam int W = sha1_pkg::WORD_W;

  sha1_pkg::back_state_t state, state_next;

  logic [4:0][W-1:0]               chain;
  logic [15:0][W-1:0]              win;
  logic [W-1:0]                    ra, rb, rc, rd, re;
  logic [sha1_pkg::ROUND_W-1:0]    round_idx;
  logic                            last_pending;
  logic [2:0]                      out_idx;

  logic [W-1:0] sched_mix;
  logic [W-1:0] sched_new;
  logic [W-1:0] t_sum;

  // Next schedule word and round sum
  assign sched_mix = win[13] ^ win[8] ^ win[2] ^ win[0];
  assign sched_new = {sched_mix[W-2:0], sched_mix[W-1]};
  assign t_sum     = {ra[W-6:0], ra[W-1:W-5]}
                   + sha1_pkg::round_f(round_idx, rb, rc, rd)
                   + re + sha1_pkg::round_k(round_idx) + win[0];

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha1_pkg::BE_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshakes
  always_comb begin
    state_next             = state;
    q_ready                = 1'b0;
    digest_out.valid       = 1'b0;
    digest_out.digest_word = chain[out_idx];
    digest_out.word_last   = (out_idx == sha1_pkg::LAST_DIGEST_IDX);
    case (state)
      sha1_pkg::BE_LOAD: begin
        q_ready = 1'b1;
        if (q_valid && q_data.block_end) begin
          state_next = sha1_pkg::BE_ROUND;
        end
      end
      sha1_pkg::BE_ROUND: begin
        if (round_idx == sha1_pkg::ROUND_LAST) begin
          state_next = sha1_pkg::BE_UPDATE;
        end
      end
      sha1_pkg::BE_UPDATE: begin
        state_next = last_pending ? sha1_pkg::BE_OUT : sha1_pkg::BE_LOAD;
      end
      sha1_pkg::BE_OUT: begin
        digest_out.valid = 1'b1;
        if (digest_out.ready && (out_idx == sha1_pkg::LAST_DIGEST_IDX)) begin
          state_next = sha1_pkg::BE_LOAD;
        end
      end
      default: begin
        state_next = sha1_pkg::BE_LOAD;
      end
    endcase
  end

  // Chaining value, counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      chain        <= sha1_pkg::H_INIT;
      round_idx    <= '0;
      last_pending <= 1'b0;
      out_idx      <= '0;
    end else begin
      case (state)
        sha1_pkg::BE_LOAD: begin
          if (q_valid && q_data.block_end) begin
            round_idx    <= '0;
            last_pending <= q_data.last_blk;
          end
        end
        sha1_pkg::BE_ROUND: begin
          round_idx <= round_idx + 1'b1;
        end
        sha1_pkg::BE_UPDATE: begin
          chain[0] <= chain[0] + ra;
          chain[1] <= chain[1] + rb;
          chain[2] <= chain[2] + rc;
          chain[3] <= chain[3] + rd;
          chain[4] <= chain[4] + re;
          out_idx  <= '0;
        end
        sha1_pkg::BE_OUT: begin
          if (digest_out.ready) begin
            if (out_idx == sha1_pkg::LAST_DIGEST_IDX) begin
              chain <= sha1_pkg::H_INIT;
            end else begin
              out_idx <= out_idx + 1'b1;
            end
          end
        end
        default: begin
          out_idx <= '0;
        end
      endcase
    end
  end

  // Working registers and schedule window
  always_ff @(posedge clk) begin
    case (state)
      sha1_pkg::BE_LOAD: begin
        if (q_valid) begin
          win <= {q_data.word, win[15:1]};
          if (q_data.block_end) begin
            ra <= chain[0];
            rb <= chain[1];
            rc <= chain[2];
            rd <= chain[3];
            re <= chain[4];
          end
        end
      end
      sha1_pkg::BE_ROUND: begin
        win <= {sched_new, win[15:1]};
        ra  <= t_sum;
        rb  <= ra;
        rc  <= {rb[1:0], rb[W-1:2]};
        rd  <= rc;
        re  <= rd;
      end
      default: begin
        ra <= ra;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/sha1_digest_engine.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_digest_engine: SHA-1 digest of a byte stream
// Top level: front end, word queue and compression core.
// ----------------------------------------------------------------------------
// Message bytes are taken one per transaction at up to one per cycle while
// the word queue has room. The compression core takes a block as 16 word
// loads, 80 rounds and one chaining update. During the rounds and the update
// the four-word queue fills with the next 16 bytes and the byte channel
// stalls. The other 48 bytes of the block then come in at one a cycle while
// the core loads. Throughput is set by the single round unit and the
// byte-wide input. The end-of-message transaction starts padding: the front
// end generates up to 18 padding and length words at one a cycle while the
// queue has room, after which the core runs one or two final blocks and
// offers the five digest words h0 to h4, one per transaction, word_last on
// h4. The front end keeps taking bytes of the next message while the digest
// is waiting to be collected, until the queue is full.
// ----------------------------------------------------------------------------
module sha1_digest_engine #(
  parameter int QUEUE_DEPTH = sha1_pkg::QUEUE_DEPTH
) (
  input  wire logic  clk,
  input  wire logic  rst,
  sha1_in_if.sink    msg_in,
  sha1_out_if.source digest_out
);

  sha1_pkg::sha1_qword_t push_data;
  logic                  push_valid;
  logic                  push_ready;
  sha1_pkg::sha1_qword_t pop_data;
  logic                  pop_valid;
  logic                  pop_ready;

  sha1_front u_front (
    .clk     (clk),
    .rst     (rst),
    .msg_in  (msg_in),
    .q_data  (push_data),
    .q_valid (push_valid),
    .q_ready (push_ready)
  );

  sha1_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_data   (push_data),
    .in_valid  (push_valid),
    .in_ready  (push_ready),
    .out_data  (pop_data),
    .out_valid (pop_valid),
    .out_ready (pop_ready)
  );

  sha1_core u_core (
    .clk        (clk),
    .rst        (rst),
    .q_data     (pop_data),
    .q_valid    (pop_valid),
    .q_ready    (pop_ready),
    .digest_out (digest_out)
  );

  // After the last digest word the core must go back to loading
  a_digest_gap: assert property (@(posedge clk) disable iff (rst)
    (digest_out.valid && digest_out.ready && digest_out.word_last) |=> !digest_out.valid)
    else $error("digest offered again straight after the last word");

  // End of message puts the front end into padding
  a_pad_hold: assert property (@(posedge clk) disable iff (rst)
    (msg_in.valid && msg_in.ready && msg_in.end_of_message) |=> !msg_in.ready)
    else $error("byte channel ready during padding");

  // A closing word must also close its block
  a_last_blk: assert property (@(posedge clk) disable iff (rst)
    (push_valid && push_data.last_blk) |-> push_data.block_end)
    else $error("message closed in the middle of a block");

endmodule
`default_nettype wire
